/* hw/rtl/lpbr_pkg.sv */
// ----------------------------------------------------------------------------
// lpbr_pkg: shared types and constants of the line page byte raster
// Holds the display size, the request item layout and the data that
// travels along the row of cells.
// ----------------------------------------------------------------------------
package lpbr_pkg;

   localparam int DISPLAY_WIDTH  = 128;
   localparam int DISPLAY_HEIGHT = 64;
   localparam int NUM_ROWS       = 8;

   typedef struct packed {
      logic [6:0] start_x;
      logic [5:0] start_y;
      logic [6:0] end_x;
      logic [5:0] end_y;
      logic [6:0] column;
      logic [2:0] page;
   } lpbr_req_type;

   // One row per cell; hit: !off, ya<=row<=yb if steep, 0 <= l <= v < l+d.
   typedef struct packed {
      logic signed [15:0] v;
      logic signed [15:0] l;
      logic signed [15:0] dv;
      logic signed [15:0] dl;
      logic        [7:0]  d;
      logic               steep;
      logic        [5:0]  ya;
      logic        [5:0]  yb;
      logic        [5:0]  row;
      logic               off;
      logic        [7:0]  pixel_byte;
   } lpbr_cell_data_type;

   typedef struct packed {
      logic load_a;
      logic load_b;
   } lpbr_front_ctl_type;

   typedef struct packed {
      logic valid_a;
      logic valid_b;
   } lpbr_front_sts_type;

endpackage

/* hw/rtl/lpbr_if.sv */
// ----------------------------------------------------------------------------
// lpbr_if: request and result channels of the line page byte raster
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lpbr_req_if;
   logic       valid;
   logic       ready;
   logic [6:0] start_x;
   logic [5:0] start_y;
   logic [6:0] end_x;
   logic [5:0] end_y;
   logic [6:0] column;
   logic [2:0] page;

   modport source (output valid, start_x, start_y, end_x, end_y, column, page,
                   input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, column, page,
                   output ready);
endinterface

interface lpbr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_byte;

   modport source (output valid, pixel_byte, input ready);
   modport sink   (input valid, pixel_byte, output ready);
endinterface

/* hw/rtl/line_page_byte_raster.sv */
// ----------------------------------------------------------------------------
// line_page_byte_raster: one display byte of a straight line
// Returns the vertical eight-pixel byte that a line lights in one column
// and page of a page-organized display.
// ----------------------------------------------------------------------------
// Usage: a request item on req_chan carries the two endpoints of a line,
// a display column and a page. For each accepted item exactly one result
// item leaves on rsp_chan, in order, carrying pixel_byte, where bit k
// stands for pixel row page*8+k.
// An accepted item passes two setup stages (bounds and operands, then two
// small multiplies) followed by a row of eight cells, one per pixel row of
// the page. Throughput is one item per cycle while results are taken;
// every stage is a pipeline register, and each cell only adds and compares
// before handing on to its neighbor.
// Each stage moves whenever the stage after it is empty or moving, so a
// stalled receiver first fills the empty stages; request ready drops only
// when all ten stages hold items. Results are held stable until taken.
// Synchronous reset empties every stage; no item is in flight afterwards.
// ----------------------------------------------------------------------------
module line_page_byte_raster (
   input  logic       clock,
   input  logic       reset,
   lpbr_req_if.sink   req_chan,
   lpbr_rsp_if.source rsp_chan
);

   lpbr_pkg::lpbr_req_type       req_item;
   lpbr_pkg::lpbr_front_ctl_type front_ctl;
   lpbr_pkg::lpbr_front_sts_type front_sts;

   // Index 0 is the output of the setup stages; index k+1 is cell k.
   lpbr_pkg::lpbr_cell_data_type chain_data  [lpbr_pkg::NUM_ROWS+1];
   logic [lpbr_pkg::NUM_ROWS:0]  chain_valid;
   // Ready of each cell and of the result side (index NUM_ROWS).
   logic [lpbr_pkg::NUM_ROWS:0]  chain_ready;
   logic ready_b, ready_a;

   always_comb begin
      req_item.start_x = req_chan.start_x;
      req_item.start_y = req_chan.start_y;
      req_item.end_x   = req_chan.end_x;
      req_item.end_y   = req_chan.end_y;
      req_item.column  = req_chan.column;
      req_item.page    = req_chan.page;
   end

   // A stage may load when it is empty or when its content moves on.
   always_comb begin
      chain_ready[lpbr_pkg::NUM_ROWS] = rsp_chan.ready;
      for (int k = lpbr_pkg::NUM_ROWS - 1; k >= 0; k--) begin
         chain_ready[k] = !chain_valid[k+1] || chain_ready[k+1];
      end
      ready_b = !front_sts.valid_b || chain_ready[0];
      ready_a = !front_sts.valid_a || ready_b;
   end

   assign front_ctl.load_a = ready_a;
   assign front_ctl.load_b = ready_b;
   assign req_chan.ready   = ready_a;

   lpbr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_item  (req_item),
      .ctl       (front_ctl),
      .sts       (front_sts),
      .data_b    (chain_data[0])
   );

   assign chain_valid[0] = front_sts.valid_b;

   for (genvar k = 0; k < lpbr_pkg::NUM_ROWS; k++) begin : g_cell
      lpbr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .load       (chain_ready[k]),
         .valid_prev (chain_valid[k]),
         .data_prev  (chain_data[k]),
         .valid_out  (chain_valid[k+1]),
         .data_out   (chain_data[k+1])
      );
   end

   // The last cell's register is the output register.
   assign rsp_chan.valid      = chain_valid[lpbr_pkg::NUM_ROWS];
   assign rsp_chan.pixel_byte = chain_data[lpbr_pkg::NUM_ROWS].pixel_byte;

endmodule

/* hw/rtl/lpbr_front.sv */
// ----------------------------------------------------------------------------
// lpbr_front: setup stages of the line page byte raster
// Stage A finds the bounds, the slope class and the multiplier operands;
// stage B forms the two products that seed the row of cells.
// ----------------------------------------------------------------------------
module lpbr_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  lpbr_pkg::lpbr_req_type      req_item,
   input  lpbr_pkg::lpbr_front_ctl_type ctl,
   output lpbr_pkg::lpbr_front_sts_type sts,
   output lpbr_pkg::lpbr_cell_data_type data_b
);

   logic [6:0] x1, x2, col;
   logic [5:0] y1, y2;
   logic [2:0] pg, p1, p2;
   logic       off, steep, swap, sneg, cneg, nneg;
   logic [6:0] dx, xa, xb, absd, ac;
   logic [5:0] dy, ya, yb, rowbase;
   logic signed [7:0] dsx, neg_dsx, m, e0, cdiff, neg_cdiff, es;
   logic signed [8:0] msteep, esh;
   logic [7:0] dsh;

   logic signed [8:0] ma_in, na_in, dl_in;
   logic        [6:0] mb_in, dv_in;
   logic        [7:0] nb_in, d_in;

   logic signed [8:0] ma_ff, na_ff, dl_ff;
   logic        [6:0] mb_ff, dv_ff;
   logic        [7:0] nb_ff, d_ff;
   logic              steep_ff, off_ff;
   logic        [5:0] ya_ff, yb_ff, row_ff;
   logic              valid_a_ff, valid_b_ff;
   lpbr_pkg::lpbr_cell_data_type data_b_in, data_b_ff;
   logic signed [16:0] prod_v, prod_l;

   always_comb begin
      x1  = req_item.start_x;
      y1  = req_item.start_y;
      x2  = req_item.end_x;
      y2  = req_item.end_y;
      col = req_item.column;
      pg  = req_item.page;
      p1  = y1[5:3];
      p2  = y2[5:3];

      off = ({2'b00, col} >= 9'(lpbr_pkg::DISPLAY_WIDTH))
         || ({6'b0, pg} >= 9'(lpbr_pkg::DISPLAY_HEIGHT / 8))
         || (col < x1 && col < x2) || (col > x1 && col > x2)
         || ((p1 < p2) ? (pg < p1 || pg > p2) : (pg > p1 || pg < p2));

      dx    = (x1 > x2) ? x1 - x2 : x2 - x1;
      dy    = (y1 > y2) ? y1 - y2 : y2 - y1;
      steep = dx < {1'b0, dy};
      rowbase = {pg, 3'b000};

      // Steep lines walk rows from the lower endpoint upward.
      swap = y1 > y2;
      ya   = swap ? y2 : y1;
      yb   = swap ? y1 : y2;
      xa   = swap ? x2 : x1;
      xb   = swap ? x1 : x2;
      dsx  = $signed({1'b0, xb}) - $signed({1'b0, xa});
      neg_dsx = -dsx;
      sneg = dsx[7];
      absd = sneg ? neg_dsx[6:0] : dsx[6:0];
      m    = $signed({1'b0, col}) - $signed({1'b0, xa});
      msteep = sneg ? -{m[7], m} : {m[7], m};
      e0   = $signed({2'b00, rowbase}) - $signed({2'b00, ya});

      // Shallow lines: the quotient sign folds into the row window.
      cdiff = $signed({1'b0, col}) - $signed({1'b0, x1});
      neg_cdiff = -cdiff;
      cneg = cdiff[7];
      ac   = cneg ? neg_cdiff[6:0] : cdiff[6:0];
      nneg = (ac != 7'd0) && (dy != 6'd0) && (cneg ^ (y2 < y1) ^ (x2 < x1));
      dsh  = (dx == 7'd0) ? 8'd1 : {1'b0, dx};
      es   = $signed({2'b00, rowbase}) - $signed({2'b00, y1});
      esh  = nneg ? -{es[7], es} : {es[7], es};

      if (steep) begin
         ma_in = {e0[7], e0};
         mb_in = absd;
         na_in = msteep;
         nb_in = {2'b00, dy};
         dv_in = absd;
         dl_in = 9'sd0;
         d_in  = {2'b00, dy};
      end else begin
         ma_in = $signed({2'b00, ac});
         mb_in = {1'b0, dy};
         na_in = esh;
         nb_in = dsh;
         dv_in = 7'd0;
         dl_in = nneg ? -$signed({1'b0, dsh}) : $signed({1'b0, dsh});
         d_in  = dsh;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_a) begin
         ma_ff    <= ma_in;
         mb_ff    <= mb_in;
         na_ff    <= na_in;
         nb_ff    <= nb_in;
         dv_ff    <= dv_in;
         dl_ff    <= dl_in;
         d_ff     <= d_in;
         steep_ff <= steep;
         off_ff   <= off;
         ya_ff    <= ya;
         yb_ff    <= yb;
         row_ff   <= rowbase;
      end
      if (ctl.load_b) begin
         data_b_ff <= data_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         if (ctl.load_a) begin
            valid_a_ff <= req_valid;
         end
         if (ctl.load_b) begin
            valid_b_ff <= valid_a_ff;
         end
      end
   end

   always_comb begin
      prod_v = ma_ff * $signed({1'b0, mb_ff});
      prod_l = na_ff * $signed({1'b0, nb_ff});
      data_b_in.v          = prod_v[15:0];
      data_b_in.l          = prod_l[15:0];
      data_b_in.dv         = $signed({9'b0, dv_ff});
      data_b_in.dl         = 16'(dl_ff);
      data_b_in.d          = d_ff;
      data_b_in.steep      = steep_ff;
      data_b_in.ya         = ya_ff;
      data_b_in.yb         = yb_ff;
      data_b_in.row        = row_ff;
      data_b_in.off        = off_ff;
      data_b_in.pixel_byte = 8'd0;
   end

   assign sts.valid_a = valid_a_ff;
   assign sts.valid_b = valid_b_ff;
   assign data_b      = data_b_ff;

endmodule

/* hw/rtl/lpbr_cell.sv */
// ----------------------------------------------------------------------------
// lpbr_cell: one row cell of the line page byte raster
// Tests one pixel row against its window, sets that row's bit, and steps
// the value and window on to the next row for the neighbor.
// ----------------------------------------------------------------------------
module lpbr_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic                         valid_prev,
   input  lpbr_pkg::lpbr_cell_data_type data_prev,
   output logic                         valid_out,
   output lpbr_pkg::lpbr_cell_data_type data_out
);

   logic hit;
   logic valid_ff;
   lpbr_pkg::lpbr_cell_data_type data_in, data_ff;

   always_comb begin
      hit = !data_prev.off
         && (!data_prev.steep || (data_prev.row >= data_prev.ya
                                  && data_prev.row <= data_prev.yb))
         && !data_prev.l[15]
         && (data_prev.l <= data_prev.v)
         && (data_prev.v < data_prev.l + $signed({8'b0, data_prev.d}));
      data_in     = data_prev;
      data_in.v   = data_prev.v + data_prev.dv;
      data_in.l   = data_prev.l + data_prev.dl;
      data_in.row = data_prev.row + 6'd1;
      data_in.pixel_byte = data_prev.pixel_byte
         | ({7'b0, hit} << data_prev.row[2:0]);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_prev;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

/* tb/sv/lpbr_tb_if.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lpbr_tb_if: testbench side of the raster channels
// The channel interfaces come from the RTL; this file only holds the item
// record that the testbench keeps for each directed request it sends.
// ----------------------------------------------------------------------------
package lpbr_tb_pkg;

   typedef struct {
      lpbr_pkg::lpbr_req_type req;
      int                     byte_known;
      logic [7:0]             known_byte;
   } line_cell_type;
endpackage

/* tb/sv/line_page_byte_raster_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_page_byte_raster_tb: self-checking bench of the line page byte raster
// Sends line/column/page requests and compares each returned pixel byte
// with a behavioral rasterizer, under random idling and long result stalls.
// ----------------------------------------------------------------------------
module line_page_byte_raster_tb;

   logic clock;
   logic reset;

   lpbr_req_if req_chan ();
   lpbr_rsp_if rsp_chan ();

   line_page_byte_raster dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // Clock with a 20 ns period.
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Expected pixel bytes, oldest first.
   logic [7:0] pending_bytes[$];
   int         error_count = 0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   bit         recv_hold = 1'b0;

   // Interpolation a + (v - v0) * (b - a) / (v1 - v0), truncating toward zero,
   // kept to 8 bits. A zero divisor gives a quotient of zero.
   function automatic logic [7:0] line_interp(int v, int v0, int v1, int a, int b);
      int den;
      int q;
      den = v1 - v0;
      q = 0;
      if (den != 0) q = ((v - v0) * (b - a)) / den;
      return 8'((q + a) & 255);
   endfunction

   // Behavioral rasterizer: the byte that the line lights in one column and page.
   function automatic logic [7:0] raster_byte(lpbr_pkg::lpbr_req_type r);
      int x1, y1, x2, y2, col, pg, p1, p2, dx, dy;
      int lo, hi, ya, yb, xa, xb;
      logic [7:0] pix;
      logic [7:0] row_y;
      x1 = r.start_x; y1 = r.start_y; x2 = r.end_x; y2 = r.end_y;
      col = r.column; pg = r.page;
      p1 = y1 >> 3; p2 = y2 >> 3;
      pix = '0;
      if (col >= lpbr_pkg::DISPLAY_WIDTH || pg >= lpbr_pkg::DISPLAY_HEIGHT / 8)
         return pix;
      if (col < x1 && col < x2) return pix;
      if (col > x1 && col > x2) return pix;
      if (p1 < p2) begin
         if (pg < p1 || pg > p2) return pix;
      end else begin
         if (pg > p1 || pg < p2) return pix;
      end
      dx = (x1 > x2) ? x1 - x2 : x2 - x1;
      dy = (y1 > y2) ? y1 - y2 : y2 - y1;
      if (dx < dy) begin
         // Steep line: walk the rows of the page inside the y span.
         ya = y1; yb = y2; xa = x1; xb = x2;
         if (ya > yb) begin
            ya = y2; yb = y1; xa = x2; xb = x1;
         end
         lo = pg * 8;
         hi = pg * 8 + 7;
         if (lo < ya) lo = ya;
         if (hi > yb) hi = yb;
         for (int t = lo; t <= hi; t++) begin
            if (int'(line_interp(t, ya, yb, xa, xb)) == col) pix[t & 7] = 1'b1;
         end
      end else begin
         // Shallow line: one row at this column, lit if it is in the page.
         row_y = line_interp(col, x1, x2, y1, y2);
         if (int'(row_y >> 3) == pg) pix[row_y[2:0]] = 1'b1;
      end
      return pix;
   endfunction

   function automatic lpbr_pkg::lpbr_req_type make_req(int sx, int sy, int ex,
                                                       int ey, int col, int pg);
      lpbr_pkg::lpbr_req_type r;
      r.start_x = 7'(sx); r.start_y = 6'(sy);
      r.end_x = 7'(ex);   r.end_y = 6'(ey);
      r.column = 7'(col); r.page = 3'(pg);
      return r;
   endfunction

   // Offer one item, with random idle cycles first, and wait for its acceptance.
   // Valid stays high after acceptance until the next idle cycle or the caller
   // drops it, so back-to-back items never assign it twice in one step.
   task automatic send_item(lpbr_pkg::lpbr_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.start_x <= r.start_x;
      req_chan.start_y <= r.start_y;
      req_chan.end_x   <= r.end_x;
      req_chan.end_y   <= r.end_y;
      req_chan.column  <= r.column;
      req_chan.page    <= r.page;
      pending_bytes.push_back(raster_byte(r));
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // A random line: mostly a real crossing of the line's box, sometimes noise.
   function automatic lpbr_pkg::lpbr_req_type random_req();
      lpbr_pkg::lpbr_req_type r;
      int lo_x, hi_x, lo_p, hi_p;
      r = lpbr_pkg::lpbr_req_type'(36'({$urandom, $urandom}));
      if ($urandom_range(3) == 0) r.end_x = 7'(r.start_x + $urandom_range(6));
      if ($urandom_range(3) == 0) r.end_y = 6'(r.start_y + $urandom_range(6));
      if ($urandom_range(9) != 0) begin
         lo_x = (r.start_x < r.end_x) ? r.start_x : r.end_x;
         hi_x = (r.start_x < r.end_x) ? r.end_x : r.start_x;
         lo_p = ((r.start_y < r.end_y) ? r.start_y : r.end_y) >> 3;
         hi_p = ((r.start_y < r.end_y) ? r.end_y : r.start_y) >> 3;
         r.column = 7'($urandom_range(hi_x, lo_x));
         r.page = 3'($urandom_range(hi_p, lo_p));
      end
      return r;
   endfunction

   // Directed rows: a known byte is typed in where it is obvious.
   lpbr_tb_pkg::line_cell_type directed_rows[$];

   task automatic add_row(lpbr_pkg::lpbr_req_type r, int known, logic [7:0] b);
      lpbr_tb_pkg::line_cell_type c;
      c.req = r;
      c.byte_known = known;
      c.known_byte = b;
      directed_rows.push_back(c);
   endtask

   // Receiver: random ready, plus a hold-off that keeps ready low.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Result checker.
   always @(posedge clock) begin
      logic [7:0] want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_bytes.size() == 0) begin
            $display("%0t: unexpected result item, pixel_byte %h", $time,
                     rsp_chan.pixel_byte);
            error_count++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_chan.pixel_byte !== want) begin
               $display("%0t: pixel_byte expected %h actual %h", $time, want,
                        rsp_chan.pixel_byte);
               error_count++;
            end
         end
      end
   end

   task automatic wait_drained();
      while (pending_bytes.size() != 0) @(posedge clock);
   endtask

   // Main stimulus.
   initial begin
      reset = 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.start_x <= '0; req_chan.start_y <= '0;
      req_chan.end_x <= '0;   req_chan.end_y <= '0;
      req_chan.column <= '0;  req_chan.page <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Single-point lines: the zero divisor lights the point itself.
      add_row(make_req(0, 0, 0, 0, 0, 0), 1, 8'h01);
      add_row(make_req(127, 63, 127, 63, 127, 7), 1, 8'h80);
      add_row(make_req(5, 13, 5, 13, 5, 1), 1, 8'h20);
      // Column or page outside the line's box gives a dark byte.
      add_row(make_req(10, 0, 20, 0, 21, 0), 1, 8'h00);
      add_row(make_req(10, 0, 20, 0, 9, 0), 1, 8'h00);
      add_row(make_req(0, 0, 127, 7, 64, 1), 1, 8'h00);
      add_row(make_req(0, 63, 127, 40, 64, 0), 1, 8'h00);
      // Horizontal and vertical lines, most of them across the full display.
      add_row(make_req(0, 63, 127, 63, 64, 7), 1, 8'h80);
      add_row(make_req(127, 0, 0, 0, 127, 0), 1, 8'h01);
      add_row(make_req(0, 0, 0, 63, 0, 3), 1, 8'hFF);
      add_row(make_req(127, 63, 127, 0, 127, 7), 1, 8'hFF);
      add_row(make_req(3, 4, 3, 10, 3, 0), 1, 8'hF0);
      // Diagonals, steep and shallow, both directions.
      add_row(make_req(0, 0, 127, 63, 64, 3), 0, 8'h00);
      add_row(make_req(127, 0, 0, 63, 100, 1), 0, 8'h00);
      add_row(make_req(0, 0, 63, 63, 20, 2), 0, 8'h00);
      add_row(make_req(10, 63, 20, 0, 15, 4), 0, 8'h00);
      add_row(make_req(20, 0, 10, 63, 11, 7), 0, 8'h00);
      add_row(make_req(0, 0, 1, 63, 0, 1), 0, 8'h00);
      add_row(make_req(127, 5, 0, 58, 0, 7), 0, 8'h00);
      add_row(make_req(85, 42, 42, 21, 63, 3), 0, 8'h00);
      add_row(make_req(1, 2, 3, 60, 2, 5), 0, 8'h00);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].byte_known != 0 &&
             raster_byte(directed_rows[i].req) !== directed_rows[i].known_byte) begin
            $display("%0t: directed row %0d expected %h actual %h", $time, i,
                     directed_rows[i].known_byte, raster_byte(directed_rows[i].req));
            error_count++;
         end
         send_item(directed_rows[i].req);
      end
      req_chan.valid <= 1'b0;

      // Sender pauses until every expected result has come.
      wait_drained();

      // Three idling phases.
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 65 : 0;
         recv_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 7 : 0;
         for (int n = 0; n < 340; n++) begin
            send_item(random_req());
         end
      end
      req_chan.valid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Long receiver hold-off early in the first random phase, so the block fills.
   initial begin
      @(negedge reset);
      wait (send_idle_pct == 7);
      repeat (60) @(posedge clock);
      recv_hold <= 1'b1;
      repeat (80) @(posedge clock);
      recv_hold <= 1'b0;
   end

   // Timeout.
   initial begin
      #5ms;
      $display("simulation failed");
      $finish;
   end

endmodule
